// ----- hdl/clpl_pkg.sv -----
package clpl_pkg;

    localparam int CAL_POINTS = 5;
    localparam int SEG_W      = 2;
    localparam int X_W        = 15;
    localparam int VAL_W      = 24;
    localparam int MODE_W     = 2;
    localparam int NUM_COEF   = 2 * (CAL_POINTS - 1);

    localparam logic [MODE_W-1:0] UNIT_KPA  = 2'd0;
    localparam logic [MODE_W-1:0] UNIT_MA   = 2'd1;
    localparam logic [MODE_W-1:0] UNIT_MMHG = 2'd2;

    localparam logic REG_MODE_CH0 = 1'b0;
    localparam logic REG_MODE_CH1 = 1'b1;

    localparam int LIN_FRAC = 62;
    localparam int OFS_LOG  = 16;
    localparam int COEF_A_W = 65;
    localparam int COEF_B_W = LIN_FRAC + OFS_LOG + 1;
    localparam int A_LO_W   = 33;
    localparam int A_HI_W   = COEF_A_W - A_LO_W;
    localparam int PP_LO_W  = A_LO_W + X_W;
    localparam int PP_HI_W  = A_HI_W + X_W;
    localparam int PSUM_W   = COEF_B_W + 1;
    localparam int SUM_W    = 82;
    localparam int Q_W      = SUM_W - LIN_FRAC;

    // calibration points: current in 1/100 mA, pressure in 1/100 Pa
    localparam longint CAL_MA [CAL_POINTS] = '{605, 684, 987, 1207, 1928};
    localparam longint CAL_PA [CAL_POINTS] = '{231647, 317375, 320200, 893690, 1721870};

    // upper sample bound of each segment but the last
    localparam logic [X_W-1:0] SEG_LIMIT [CAL_POINTS-2] = '{
        X_W'(CAL_MA[1] * 1024 / 100),
        X_W'(CAL_MA[2] * 1024 / 100),
        X_W'(CAL_MA[3] * 1024 / 100)
    };

    function automatic longint seg_dma(int s);
        return CAL_MA[s+1] - CAL_MA[s];
    endfunction

    function automatic longint seg_dpa(int s);
        return CAL_PA[s+1] - CAL_PA[s];
    endfunction

    function automatic longint seg_k(int s);
        return 1024 * (CAL_PA[s] * seg_dma(s) - CAL_MA[s] * seg_dpa(s));
    endfunction

    // rounded value = (lin_q * x + lin_p) / lin_den - offset, floored
    function automatic longint lin_den(bit mmhg, int s);
        return mmhg ? seg_dma(s) * 64'sd40000000000 : seg_dma(s) * 64'sd6400000;
    endfunction

    function automatic longint lin_q(bit mmhg, int s);
        return mmhg ? seg_dpa(s) * 64'sd75006200 : seg_dpa(s) * 64'sd1600;
    endfunction

    function automatic longint lin_p(bit mmhg, int s);
        longint den;
        den = lin_den(mmhg, s);
        return (mmhg ? seg_k(s) * 64'sd750062 : seg_k(s) * 64'sd16)
            + den / 2 + (longint'(1) << OFS_LOG) * den;
    endfunction

    localparam logic [127:0] LIN_DEN [NUM_COEF] = '{
        128'(lin_den(1'b0, 0)), 128'(lin_den(1'b0, 1)),
        128'(lin_den(1'b0, 2)), 128'(lin_den(1'b0, 3)),
        128'(lin_den(1'b1, 0)), 128'(lin_den(1'b1, 1)),
        128'(lin_den(1'b1, 2)), 128'(lin_den(1'b1, 3))
    };

    localparam logic [127:0] LIN_QN [NUM_COEF] = '{
        128'(lin_q(1'b0, 0)) << LIN_FRAC, 128'(lin_q(1'b0, 1)) << LIN_FRAC,
        128'(lin_q(1'b0, 2)) << LIN_FRAC, 128'(lin_q(1'b0, 3)) << LIN_FRAC,
        128'(lin_q(1'b1, 0)) << LIN_FRAC, 128'(lin_q(1'b1, 1)) << LIN_FRAC,
        128'(lin_q(1'b1, 2)) << LIN_FRAC, 128'(lin_q(1'b1, 3)) << LIN_FRAC
    };

    localparam logic [127:0] LIN_PN [NUM_COEF] = '{
        128'(lin_p(1'b0, 0)) << LIN_FRAC, 128'(lin_p(1'b0, 1)) << LIN_FRAC,
        128'(lin_p(1'b0, 2)) << LIN_FRAC, 128'(lin_p(1'b0, 3)) << LIN_FRAC,
        128'(lin_p(1'b1, 0)) << LIN_FRAC, 128'(lin_p(1'b1, 1)) << LIN_FRAC,
        128'(lin_p(1'b1, 2)) << LIN_FRAC, 128'(lin_p(1'b1, 3)) << LIN_FRAC
    };

    // slopes and intercepts rounded up, exact after the final floor
    localparam logic [COEF_A_W-1:0] LIN_A [NUM_COEF] = '{
        COEF_A_W'((LIN_QN[0] + LIN_DEN[0] - 128'd1) / LIN_DEN[0]),
        COEF_A_W'((LIN_QN[1] + LIN_DEN[1] - 128'd1) / LIN_DEN[1]),
        COEF_A_W'((LIN_QN[2] + LIN_DEN[2] - 128'd1) / LIN_DEN[2]),
        COEF_A_W'((LIN_QN[3] + LIN_DEN[3] - 128'd1) / LIN_DEN[3]),
        COEF_A_W'((LIN_QN[4] + LIN_DEN[4] - 128'd1) / LIN_DEN[4]),
        COEF_A_W'((LIN_QN[5] + LIN_DEN[5] - 128'd1) / LIN_DEN[5]),
        COEF_A_W'((LIN_QN[6] + LIN_DEN[6] - 128'd1) / LIN_DEN[6]),
        COEF_A_W'((LIN_QN[7] + LIN_DEN[7] - 128'd1) / LIN_DEN[7])
    };

    localparam logic [COEF_B_W-1:0] LIN_B [NUM_COEF] = '{
        COEF_B_W'((LIN_PN[0] + LIN_DEN[0] - 128'd1) / LIN_DEN[0]),
        COEF_B_W'((LIN_PN[1] + LIN_DEN[1] - 128'd1) / LIN_DEN[1]),
        COEF_B_W'((LIN_PN[2] + LIN_DEN[2] - 128'd1) / LIN_DEN[2]),
        COEF_B_W'((LIN_PN[3] + LIN_DEN[3] - 128'd1) / LIN_DEN[3]),
        COEF_B_W'((LIN_PN[4] + LIN_DEN[4] - 128'd1) / LIN_DEN[4]),
        COEF_B_W'((LIN_PN[5] + LIN_DEN[5] - 128'd1) / LIN_DEN[5]),
        COEF_B_W'((LIN_PN[6] + LIN_DEN[6] - 128'd1) / LIN_DEN[6]),
        COEF_B_W'((LIN_PN[7] + LIN_DEN[7] - 128'd1) / LIN_DEN[7])
    };

    localparam logic [COEF_A_W-1:0] MA_A  = COEF_A_W'(1) << (LIN_FRAC - 2);
    localparam logic [COEF_B_W-1:0] OFF_B = COEF_B_W'(1) << (LIN_FRAC + OFS_LOG);
    localparam logic [COEF_B_W-1:0] MA_B  = OFF_B | (COEF_B_W'(1) << (LIN_FRAC - 1));

    typedef struct packed {
        logic             ch;
        logic [SEG_W-1:0] seg;
    } t_meta;

    typedef struct packed {
        logic              valid;
        logic              ch;
        logic [X_W-1:0]    x;
        logic [MODE_W-1:0] mode;
    } t_in_stage;

    typedef struct packed {
        logic                valid;
        t_meta               meta;
        logic [X_W-1:0]      x;
        logic [COEF_A_W-1:0] a;
        logic [COEF_B_W-1:0] b;
    } t_coef_stage;

    typedef struct packed {
        logic                    valid;
        t_meta                   meta;
        logic signed [VAL_W-1:0] value;
    } t_out_stage;

endpackage

// ----- hdl/clpl_coef.sv -----
module clpl_coef (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  clpl_pkg::t_in_stage   i_in,
    output clpl_pkg::t_coef_stage o_coef
);

    clpl_pkg::t_coef_stage            r_coef;
    clpl_pkg::t_coef_stage            n_coef;
    logic [clpl_pkg::SEG_W-1:0]       w_seg;

    // first segment whose upper point is not below the sample
    always_comb begin
        w_seg = clpl_pkg::SEG_W'(clpl_pkg::CAL_POINTS - 2);
        for (int i = clpl_pkg::CAL_POINTS - 3; i >= 0; i--) begin
            if (i_in.x <= clpl_pkg::SEG_LIMIT[i]) begin
                w_seg = clpl_pkg::SEG_W'(i);
            end
        end
    end

    always_comb begin
        n_coef.valid    = i_in.valid;
        n_coef.meta.ch  = i_in.ch;
        n_coef.meta.seg = w_seg;
        n_coef.x        = i_in.x;
        unique case (i_in.mode)
            clpl_pkg::UNIT_KPA: begin
                n_coef.a = clpl_pkg::LIN_A[{1'b0, w_seg}];
                n_coef.b = clpl_pkg::LIN_B[{1'b0, w_seg}];
            end
            clpl_pkg::UNIT_MMHG: begin
                n_coef.a = clpl_pkg::LIN_A[{1'b1, w_seg}];
                n_coef.b = clpl_pkg::LIN_B[{1'b1, w_seg}];
            end
            clpl_pkg::UNIT_MA: begin
                n_coef.a = clpl_pkg::MA_A;
                n_coef.b = clpl_pkg::MA_B;
            end
            default: begin
                n_coef.a = '0;
                n_coef.b = clpl_pkg::OFF_B;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.valid <= 1'b0;
        end else if (i_en) begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

// ----- hdl/clpl_mac.sv -----
module clpl_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  clpl_pkg::t_coef_stage i_coef,
    output clpl_pkg::t_out_stage  o_res
);

    logic                             r_pp_valid;
    clpl_pkg::t_meta                  r_pp_meta;
    logic [clpl_pkg::PP_LO_W-1:0]     r_pp_lo;
    logic [clpl_pkg::PP_HI_W-1:0]     r_pp_hi;
    logic [clpl_pkg::COEF_B_W-1:0]    r_pp_b;

    logic                             r_ps_valid;
    clpl_pkg::t_meta                  r_ps_meta;
    logic [clpl_pkg::PSUM_W-1:0]      r_ps_lo;
    logic [clpl_pkg::PP_HI_W-1:0]     r_ps_hi;

    clpl_pkg::t_out_stage             r_res;

    logic [clpl_pkg::PP_LO_W-1:0]     n_pp_lo;
    logic [clpl_pkg::PP_HI_W-1:0]     n_pp_hi;
    logic [clpl_pkg::PSUM_W-1:0]      n_ps_lo;
    logic [clpl_pkg::SUM_W-1:0]       w_sum;
    logic [clpl_pkg::Q_W-1:0]         w_q;
    logic signed [clpl_pkg::Q_W-1:0]  w_val;
    clpl_pkg::t_out_stage             n_res;

    // slope split in two halves, each a narrow product
    always_comb begin
        n_pp_lo = clpl_pkg::PP_LO_W'(i_coef.x)
                * clpl_pkg::PP_LO_W'(i_coef.a[clpl_pkg::A_LO_W-1:0]);
        n_pp_hi = clpl_pkg::PP_HI_W'(i_coef.x)
                * clpl_pkg::PP_HI_W'(i_coef.a[clpl_pkg::COEF_A_W-1:clpl_pkg::A_LO_W]);
    end

    assign n_ps_lo = clpl_pkg::PSUM_W'(r_pp_b) + clpl_pkg::PSUM_W'(r_pp_lo);

    always_comb begin
        w_sum = clpl_pkg::SUM_W'(r_ps_lo)
              + (clpl_pkg::SUM_W'(r_ps_hi) << clpl_pkg::A_LO_W);
        w_q   = w_sum[clpl_pkg::SUM_W-1:clpl_pkg::LIN_FRAC];
        // remove the bias that kept the sum positive
        w_val = signed'(w_q - (clpl_pkg::Q_W'(1) << clpl_pkg::OFS_LOG));
        n_res.valid = r_ps_valid;
        n_res.meta  = r_ps_meta;
        n_res.value = clpl_pkg::VAL_W'(w_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid  <= 1'b0;
            r_ps_valid  <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_pp_valid <= i_coef.valid;
            r_ps_valid <= r_pp_valid;
            r_res      <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_meta <= i_coef.meta;
            r_pp_lo   <= n_pp_lo;
            r_pp_hi   <= n_pp_hi;
            r_pp_b    <= i_coef.b;
            r_ps_meta <= r_pp_meta;
            r_ps_lo   <= n_ps_lo;
            r_ps_hi   <= r_pp_hi;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hdl/current_loop_pressure_linearizer_core.sv -----
// Loop-current pressure linearizer, two sensor channels.
// Input channel: i_valid/o_ready carry one item, a channel number and a
// current sample in 1/1024 mA. Output channel: o_valid/i_ready carry one
// result per item: channel, value in 1/256 of the channel's unit and the
// calibration segment used. Results leave in the order items arrive.
// Pipeline: input register, segment search and coefficient lookup, split
// slope multiply, partial sum, final add into the output register. One item
// is taken every cycle unless the receiver stalls the output; the rate is
// set by the five register stages all moving on one enable.
// When the receiver holds i_ready low with a result waiting, the whole
// pipeline freezes and o_ready drops in the same cycle; nothing is lost.
// APB port: register 0 at address 0 (unit of channel 0), register 1 at
// address 4 (unit of channel 1); 0 kPa, 1 mA, 2 mmHg, code 3 gives zero.
// The unit is latched with each item as it enters, so change it only while
// the pipeline is empty. Synchronous reset empties the pipeline and sets
// both units to kPa.
module current_loop_pressure_linearizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_channel,
    input  logic [clpl_pkg::X_W-1:0]    i_current_sample,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_channel_out,
    output logic signed [clpl_pkg::VAL_W-1:0] o_primary_value,
    output logic [clpl_pkg::SEG_W-1:0]  o_segment,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [clpl_pkg::MODE_W-1:0] r_mode_ch0;
    logic [clpl_pkg::MODE_W-1:0] r_mode_ch1;
    clpl_pkg::t_in_stage         r_in;
    clpl_pkg::t_in_stage         n_in;
    clpl_pkg::t_coef_stage       w_coef;
    clpl_pkg::t_out_stage        w_res;
    logic                        w_en;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_ch0 <= clpl_pkg::UNIT_KPA;
            r_mode_ch1 <= clpl_pkg::UNIT_KPA;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                clpl_pkg::REG_MODE_CH0: r_mode_ch0 <= pwdata[clpl_pkg::MODE_W-1:0];
                clpl_pkg::REG_MODE_CH1: r_mode_ch1 <= pwdata[clpl_pkg::MODE_W-1:0];
                default:                r_mode_ch0 <= r_mode_ch0;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            clpl_pkg::REG_MODE_CH0: prdata = 32'(r_mode_ch0);
            clpl_pkg::REG_MODE_CH1: prdata = 32'(r_mode_ch1);
            default:                prdata = '0;
        endcase
    end

    // pipeline moves whenever the output register is free or being taken
    assign w_en    = !w_res.valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        n_in.valid = i_valid;
        n_in.ch    = i_channel;
        n_in.x     = i_current_sample;
        n_in.mode  = i_channel ? r_mode_ch1 : r_mode_ch0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    clpl_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_in    (r_in),
        .o_coef  (w_coef)
    );

    clpl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_coef  (w_coef),
        .o_res   (w_res)
    );

    assign o_valid         = w_res.valid;
    assign o_channel_out   = w_res.meta.ch;
    assign o_primary_value = w_res.value;
    assign o_segment       = w_res.meta.seg;

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_in.valid, w_coef.valid, w_res.valid}))
        else $error("pipeline valid bits moved during a stall");

    a_item_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_in.valid) |=> w_coef.valid)
        else $error("item dropped between input and coefficient stage");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && paddr[2] == clpl_pkg::REG_MODE_CH1)
        |=> r_mode_ch1 == $past(pwdata[clpl_pkg::MODE_W-1:0]))
        else $error("channel 1 unit register not updated");

endmodule
